// ----- rtl/core/artq_pkg.sv -----
// Shared types and constants of the acknowledged-retry transmit queue.
package artq_pkg;

	// Operation codes on the input channel
	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_POLL   = 3'd1;
	localparam logic [2:0] OP_FOUND  = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_RTIMER = 3'd4;

	// Result event codes
	localparam logic [2:0] EV_DONE    = 3'd0;
	localparam logic [2:0] EV_WAIT    = 3'd1;
	localparam logic [2:0] EV_GAVE_UP = 3'd2;
	localparam logic [2:0] EV_SEND    = 3'd3;
	localparam logic [2:0] EV_ADDED   = 3'd4;
	localparam logic [2:0] EV_FULL    = 3'd5;

	// Register indexes (address bit 2 selects)
	localparam logic REG_MIN_RETRY = 1'b0;
	localparam logic REG_MAX_TRIES = 1'b1;

	// Reset values of the registers
	localparam logic [15:0] MIN_RETRY_RST = 16'd5;
	localparam logic [7:0]  MAX_TRIES_RST = 8'd3;

	// ceil(ms / 1000) = ((ms + 999) >> 3) * 8389 >> 20, exact for 16-bit ms
	localparam logic [16:0] AIR_BIAS    = 17'd999;
	localparam logic [27:0] AIR_RECIP   = 28'd8389;
	localparam int          AIR_SHIFT   = 20;
	localparam int          ASEC_W      = 7;
	localparam int          TIMER_W     = 17;
	localparam logic [7:0]  TRIES_MAX   = 8'hFF;

	typedef enum logic [2:0] {
		K_ADD,
		K_POLL,
		K_FOUND,
		K_REMOVE,
		K_RTIMER,
		K_NOP
	} cmd_kind_t;

	// One stored descriptor: airtime is kept as whole seconds, rounded up
	typedef struct packed {
		logic [15:0]       handle;
		logic              bcast;
		logic [15:0]       repeater;
		logic              slot;
		logic              group;
		logic              resp;
		logic [ASEC_W-1:0] asec;
	} entry_t;

	// Classified command passed from front to back
	typedef struct packed {
		cmd_kind_t kind;
		logic      tick;
		logic      busy;
		entry_t    desc;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         ev;
		logic [15:0]        handle;
		logic               bcast;
		logic [15:0]        repeater;
		logic               slot;
		logic [TIMER_W-1:0] wait_sec;
		logic [7:0]         tries;
		logic [4:0]         count;
		logic               last;
	} result_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EXEC,
		B_READ2,
		B_SEND2,
		B_SEND3
	} back_state_t;

endpackage

// ----- rtl/core/artq_front.sv -----
// Front end: accepts input transfers, classifies them and queues commands.
module artq_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           op,
	input  logic                 tick,
	input  logic                 channel_busy,
	input  logic [15:0]          packet_handle,
	input  logic                 broadcast,
	input  logic [15:0]          repeater_id,
	input  logic                 timeslot,
	input  logic                 dest_is_group,
	input  logic                 wants_response,
	input  logic [15:0]          airtime_ms,
	output logic                 cmd_valid,
	input  logic                 cmd_pop,
	output artq_pkg::cmd_t       cmd
);

	localparam int FQ_DEPTH = 2;

	artq_pkg::cmd_t       fq_q [FQ_DEPTH];
	artq_pkg::cmd_t       cls;
	logic                 wptr_q;
	logic                 rptr_q;
	logic [1:0]           fcnt_q;
	logic                 push;
	logic [16:0]          air_sum;
	logic [27:0]          air_prod;

	// Airtime rounded up to whole seconds by reciprocal multiply
	assign air_sum  = 17'(airtime_ms) + artq_pkg::AIR_BIAS;
	assign air_prod = 28'(air_sum[16:3]) * artq_pkg::AIR_RECIP;

	// Classify the op and build the command
	always_comb begin
		cls.tick           = tick;
		cls.busy           = channel_busy;
		cls.desc.handle    = packet_handle;
		cls.desc.bcast     = broadcast;
		cls.desc.repeater  = repeater_id;
		cls.desc.slot      = timeslot;
		cls.desc.group     = dest_is_group;
		cls.desc.resp      = wants_response;
		cls.desc.asec      = air_prod[artq_pkg::AIR_SHIFT +: artq_pkg::ASEC_W];
		case (op)
			artq_pkg::OP_ADD:    cls.kind = artq_pkg::K_ADD;
			artq_pkg::OP_POLL:   cls.kind = artq_pkg::K_POLL;
			artq_pkg::OP_FOUND:  cls.kind = artq_pkg::K_FOUND;
			artq_pkg::OP_REMOVE: cls.kind = artq_pkg::K_REMOVE;
			artq_pkg::OP_RTIMER: cls.kind = artq_pkg::K_RTIMER;
			default:             cls.kind = artq_pkg::K_NOP;
		endcase
	end

	assign in_stall  = (fcnt_q == 2'(FQ_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (fcnt_q != 2'd0);
	assign cmd       = fq_q[rptr_q];

	// Command queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fq_q[wptr_q] <= cls;
		end
	end

	// Command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fcnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (cmd_pop) begin
				rptr_q <= ~rptr_q;
			end
			fcnt_q <= fcnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

// ----- rtl/core/artq_back.sv -----
// Back end: descriptor ring, retry timer, head sequencer and result register.
module artq_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_pop,
	input  artq_pkg::cmd_t        cmd,
	input  logic [15:0]           min_retry,
	input  logic [7:0]            max_tries,
	output logic                  out_valid,
	input  logic                  out_stall,
	output artq_pkg::result_t     res
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = artq_pkg::TIMER_W;

	artq_pkg::back_state_t state_q, state_d;
	artq_pkg::cmd_t        cur_q;
	artq_pkg::entry_t      entry_mem_q [QUEUE_DEPTH];
	artq_pkg::entry_t      rd_q;
	artq_pkg::entry_t      gv_q;
	logic [7:0]            gv_tries_q;
	logic [PW-1:0]         head_q, head_d;
	logic [PW-1:0]         tail_q, tail_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [7:0]            tries_q, tries_d;
	logic [TW-1:0]         since_q, since_d;
	artq_pkg::result_t     out_q, out_d;
	logic                  out_valid_q;
	logic                  out_ld;
	logic                  out_free;
	logic                  stash_ld;
	logic                  mem_we;
	logic [PW-1:0]         mem_wa;
	artq_pkg::entry_t      mem_wd;
	logic                  empty;
	logic                  full;
	logic [TW-1:0]         timeout;
	logic                  early;
	logic                  give_up;
	logic                  more;
	logic                  drop1;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic artq_pkg::result_t with_desc(input artq_pkg::result_t r,
			input artq_pkg::entry_t d);
		artq_pkg::result_t t;
		t          = r;
		t.handle   = d.handle;
		t.bcast    = d.bcast;
		t.repeater = d.repeater;
		t.slot     = d.slot;
		return t;
	endfunction

	// Head status
	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == CW'(QUEUE_DEPTH));
	assign timeout  = TW'(min_retry) + TW'(rd_q.asec);
	assign early    = (since_q < timeout);
	assign give_up  = (tries_q >= max_tries);
	assign more     = (cnt_q != CW'(1));
	assign drop1    = rd_q.group || !rd_q.resp;
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			artq_pkg::B_IDLE: begin
				if (cmd_valid) begin
					state_d = artq_pkg::B_EXEC;
				end
			end
			artq_pkg::B_EXEC: begin
				if (out_free) begin
					if (cur_q.kind == artq_pkg::K_POLL && !empty && !cur_q.busy && !early
							&& give_up && more) begin
						state_d = artq_pkg::B_READ2;
					end else begin
						state_d = artq_pkg::B_IDLE;
					end
				end
			end
			artq_pkg::B_READ2: state_d = artq_pkg::B_SEND2;
			artq_pkg::B_SEND2: begin
				if (out_free) begin
					state_d = artq_pkg::B_SEND3;
				end
			end
			artq_pkg::B_SEND3: begin
				if (out_free) begin
					state_d = artq_pkg::B_IDLE;
				end
			end
			default: state_d = artq_pkg::B_IDLE;
		endcase
	end

	// Datapath and result outputs
	always_comb begin
		cmd_pop  = 1'b0;
		out_ld   = 1'b0;
		stash_ld = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = tail_q;
		mem_wd   = cur_q.desc;
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		tries_d  = tries_q;
		since_d  = since_q;
		out_d    = '0;
		case (state_q)
			artq_pkg::B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					// one-second tick counts before the poll is processed
					if (cmd.kind == artq_pkg::K_POLL && cmd.tick && since_q != '1) begin
						since_d = since_q + TW'(1);
					end
				end
			end
			artq_pkg::B_EXEC: begin
				if (out_free) begin
					out_ld = 1'b1;
					out_d.ev = artq_pkg::EV_DONE;
					case (cur_q.kind)
						artq_pkg::K_ADD: begin
							out_d = with_desc(out_d, cur_q.desc);
							if (full) begin
								out_d.ev = artq_pkg::EV_FULL;
							end else begin
								out_d.ev = artq_pkg::EV_ADDED;
								mem_we   = 1'b1;
								tail_d   = nxt(tail_q);
								cnt_d    = cnt_q + CW'(1);
								if (empty) begin
									tries_d = '0;
								end
							end
						end
						artq_pkg::K_POLL: begin
							if (!empty) begin
								out_d = with_desc(out_d, rd_q);
								if (cur_q.busy || early) begin
									out_d.ev       = artq_pkg::EV_WAIT;
									out_d.wait_sec = early ? (timeout - since_q) : '0;
								end else if (give_up) begin
									out_d.ev    = artq_pkg::EV_GAVE_UP;
									out_d.tries = tries_q;
									head_d      = nxt(head_q);
									cnt_d       = cnt_q - CW'(1);
									tries_d     = '0;
									// with another entry left, report after the next read
									if (more) begin
										out_ld   = 1'b0;
										stash_ld = 1'b1;
									end
								end else begin
									out_d.ev    = artq_pkg::EV_SEND;
									out_d.tries = tries_q;
									since_d     = '0;
									if (drop1) begin
										head_d  = nxt(head_q);
										cnt_d   = cnt_q - CW'(1);
										tries_d = '0;
									end else if (tries_q != artq_pkg::TRIES_MAX) begin
										tries_d = tries_q + 8'd1;
									end
								end
							end
						end
						artq_pkg::K_FOUND: begin
							if (!empty) begin
								mem_we          = 1'b1;
								mem_wa          = head_q;
								mem_wd          = rd_q;
								mem_wd.repeater = cur_q.desc.repeater;
								mem_wd.slot     = cur_q.desc.slot;
								mem_wd.bcast    = 1'b0;
								out_d           = with_desc(out_d, mem_wd);
							end
						end
						artq_pkg::K_REMOVE: begin
							if (!empty) begin
								out_d   = with_desc(out_d, rd_q);
								head_d  = nxt(head_q);
								cnt_d   = cnt_q - CW'(1);
								tries_d = '0;
							end
						end
						artq_pkg::K_RTIMER: since_d = '0;
						default: ;
					endcase
					out_d.count = 5'(cnt_d);
					out_d.last  = 1'b1;
				end
			end
			artq_pkg::B_SEND2: begin
				// gave-up transfer; count already reflects the new head's fate
				if (out_free) begin
					out_ld      = 1'b1;
					out_d       = with_desc(out_d, gv_q);
					out_d.ev    = artq_pkg::EV_GAVE_UP;
					out_d.tries = gv_tries_q;
					out_d.count = 5'(cnt_q - CW'(drop1));
					out_d.last  = 1'b0;
				end
			end
			artq_pkg::B_SEND3: begin
				if (out_free) begin
					out_ld      = 1'b1;
					out_d       = with_desc(out_d, rd_q);
					out_d.ev    = artq_pkg::EV_SEND;
					out_d.tries = tries_q;
					since_d     = '0;
					if (drop1) begin
						head_d  = nxt(head_q);
						cnt_d   = cnt_q - CW'(1);
						tries_d = '0;
					end else if (tries_q != artq_pkg::TRIES_MAX) begin
						tries_d = tries_q + 8'd1;
					end
					out_d.count = 5'(cnt_d);
					out_d.last  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Descriptor ring with registered head read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= entry_mem_q[head_q];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (stash_ld) begin
			gv_q       <= rd_q;
			gv_tries_q <= tries_q;
		end
		if (out_ld) begin
			out_q <= out_d;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= artq_pkg::B_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			tries_q     <= '0;
			since_q     <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			tries_q <= tries_d;
			since_q <= since_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("entry count beyond ring depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (head_q == tail_q))
		else $error("empty ring with unequal pointers");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CW'(QUEUE_DEPTH)) |-> (head_q == tail_q))
		else $error("full ring with unequal pointers");

	a_gave_then_send: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ld && out_d.ev == artq_pkg::EV_GAVE_UP && !out_d.last)
		|=> (state_q == artq_pkg::B_SEND3))
		else $error("non-final gave-up transfer not followed by send");

	a_send3_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == artq_pkg::B_SEND3) |-> (cnt_q != '0))
		else $error("send of new head with empty ring");

endmodule

// ----- rtl/core/ack_retry_tx_queue_core.sv -----
// Top level of the acknowledged-retry transmit queue: registers, front and back.
// An input transfer is queued in the front; the back pops the command while
// the head entry is fetched, then executes it into the registered result once the
// result register is free, and pops no new command until then. A poll that gives
// up the head with entries left then reads the new head and gives both results.
// Reset (arst_n low) empties the ring, clears the try count, saturates the timer.
module ack_retry_tx_queue_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic        tick,
	input  logic        channel_busy,
	input  logic [15:0] packet_handle,
	input  logic        broadcast,
	input  logic [15:0] repeater_id,
	input  logic        timeslot,
	input  logic        dest_is_group,
	input  logic        wants_response,
	input  logic [15:0] airtime_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [15:0] out_handle,
	output logic        out_broadcast,
	output logic [15:0] out_repeater,
	output logic        out_timeslot,
	output logic [16:0] wait_seconds,
	output logic [7:0]  try_number,
	output logic [4:0]  queue_count,
	output logic        last
);

	logic [15:0]       min_retry_q;
	logic [7:0]        max_tries_q;
	logic              cmd_valid;
	logic              cmd_pop;
	artq_pkg::cmd_t    cmd;
	artq_pkg::result_t res;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_retry_q <= artq_pkg::MIN_RETRY_RST;
			max_tries_q <= artq_pkg::MAX_TRIES_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				artq_pkg::REG_MIN_RETRY: min_retry_q <= pwdata[15:0];
				artq_pkg::REG_MAX_TRIES: max_tries_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			artq_pkg::REG_MIN_RETRY: prdata = 32'(min_retry_q);
			artq_pkg::REG_MAX_TRIES: prdata = 32'(max_tries_q);
			default:                 prdata = '0;
		endcase
	end

	artq_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.tick           (tick),
		.channel_busy   (channel_busy),
		.packet_handle  (packet_handle),
		.broadcast      (broadcast),
		.repeater_id    (repeater_id),
		.timeslot       (timeslot),
		.dest_is_group  (dest_is_group),
		.wants_response (wants_response),
		.airtime_ms     (airtime_ms),
		.cmd_valid      (cmd_valid),
		.cmd_pop        (cmd_pop),
		.cmd            (cmd)
	);

	artq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.min_retry (min_retry_q),
		.max_tries (max_tries_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// Result fields
	assign event_res     = res.ev;
	assign out_handle    = res.handle;
	assign out_broadcast = res.bcast;
	assign out_repeater  = res.repeater;
	assign out_timeslot  = res.slot;
	assign wait_seconds  = res.wait_sec;
	assign try_number    = res.tries;
	assign queue_count   = res.count;
	assign last          = res.last;

endmodule

// ----- test/tb_ack_retry_tx_queue_core.sv -----
// Self-checking testbench of the acknowledged-retry transmit queue core.
module tb_ack_retry_tx_queue_core;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;
	localparam int LOG_CAP     = 60;
	localparam int PHASE_ITEMS = 75;
	localparam logic [16:0] TIMER_FULL = 17'h1FFFF;

	// Op codes the block treats as no-ops
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic        tick;
		logic        busy;
		logic [15:0] handle;
		logic        bcast;
		logic [15:0] rep;
		logic        slot;
		logic        grp;
		logic        resp;
		logic [15:0] air;
	} txq_item_t;

	typedef struct {
		logic [15:0] handle;
		logic        bcast;
		logic [15:0] rep;
		logic        slot;
		logic        grp;
		logic        resp;
		logic [15:0] air;
	} txq_desc_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = artq_pkg::OP_ADD;
	logic        tick = 1'b0;
	logic        channel_busy = 1'b0;
	logic [15:0] packet_handle = '0;
	logic        broadcast = 1'b0;
	logic [15:0] repeater_id = '0;
	logic        timeslot = 1'b0;
	logic        dest_is_group = 1'b0;
	logic        wants_response = 1'b0;
	logic [15:0] airtime_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_res;
	logic [15:0] out_handle;
	logic        out_broadcast;
	logic [15:0] out_repeater;
	logic        out_timeslot;
	logic [16:0] wait_seconds;
	logic [7:0]  try_number;
	logic [4:0]  queue_count;
	logic        last;

	ack_retry_tx_queue_core #(
		.QUEUE_DEPTH(DEPTH)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .tick(tick), .channel_busy(channel_busy),
		.packet_handle(packet_handle), .broadcast(broadcast),
		.repeater_id(repeater_id), .timeslot(timeslot),
		.dest_is_group(dest_is_group), .wants_response(wants_response),
		.airtime_ms(airtime_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .out_handle(out_handle),
		.out_broadcast(out_broadcast), .out_repeater(out_repeater),
		.out_timeslot(out_timeslot), .wait_seconds(wait_seconds),
		.try_number(try_number), .queue_count(queue_count), .last(last)
	);

	// Shadow of the block's state and registers
	txq_desc_t   q_store [DEPTH];
	int          q_head = 0;
	int          q_tail = 0;
	int          q_count = 0;
	logic [7:0]  q_tries = '0;
	logic [16:0] q_timer = TIMER_FULL;
	logic [15:0] cfg_min_retry = artq_pkg::MIN_RETRY_RST;
	logic [7:0]  cfg_max_tries = artq_pkg::MAX_TRIES_RST;

	artq_pkg::result_t due_events [$];
	txq_item_t backlog [$];
	txq_item_t on_bus;
	int n_loaded = 0;
	int n_taken = 0;
	int n_checked = 0;
	int fault_count = 0;
	int cycle_count = 0;
	int src_idle_pct = 7;
	int snk_stall_pct = 52;
	int ops_seen [8] = '{default: 0};
	int ev_seen [8] = '{default: 0};

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= LOG_CAP)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic artq_pkg::result_t describe(input logic [2:0] ev,
			input txq_desc_t d, input bit known, input int w_left,
			input logic [7:0] tries);
		artq_pkg::result_t r;
		r.ev       = ev;
		r.handle   = known ? d.handle : '0;
		r.bcast    = known ? d.bcast : 1'b0;
		r.repeater = known ? d.rep : '0;
		r.slot     = known ? d.slot : 1'b0;
		r.wait_sec = w_left[16:0];
		r.tries    = tries;
		r.count    = '0;
		r.last     = 1'b0;
		return r;
	endfunction

	function automatic void pop_head();
		if (q_count != 0) begin
			q_head = (q_head + 1) % DEPTH;
			q_count--;
			q_tries = '0;
		end
	endfunction

	// Works out the results of one accepted item and advances the shadow state
	function automatic void retx_queue_step(input txq_item_t it);
		artq_pkg::result_t outs [$];
		txq_desc_t nd;
		txq_desc_t hd;
		int        tmo;
		int        w_left;
		bit        have;
		nd = '{it.handle, it.bcast, it.rep, it.slot, it.grp, it.resp, it.air};
		hd = nd;
		case (it.op)
			artq_pkg::OP_ADD: begin
				if (q_count >= DEPTH) begin
					outs.push_back(describe(artq_pkg::EV_FULL, nd, 1, 0, '0));
				end else begin
					if (q_count == 0)
						q_tries = '0;
					q_store[q_tail] = nd;
					q_tail = (q_tail + 1) % DEPTH;
					q_count++;
					outs.push_back(describe(artq_pkg::EV_ADDED, nd, 1, 0, '0));
				end
			end
			artq_pkg::OP_POLL: begin
				if (it.tick && q_timer != TIMER_FULL)
					q_timer++;
				if (q_count == 0) begin
					outs.push_back(describe(artq_pkg::EV_DONE, nd, 0, 0, '0));
				end else begin
					hd = q_store[q_head];
					tmo = int'(cfg_min_retry) + (int'(hd.air) + 999) / 1000;
					if (it.busy || int'(q_timer) < tmo) begin
						w_left = (int'(q_timer) < tmo) ? tmo - int'(q_timer) : 0;
						outs.push_back(describe(artq_pkg::EV_WAIT, hd, 1, w_left, '0));
					end else begin
						have = 1;
						// head used up its tries: give it up, then try the next one
						if (q_tries >= cfg_max_tries) begin
							outs.push_back(describe(artq_pkg::EV_GAVE_UP, hd, 1, 0,
								q_tries));
							pop_head();
							have = (q_count != 0);
						end
						if (have) begin
							hd = q_store[q_head];
							outs.push_back(describe(artq_pkg::EV_SEND, hd, 1, 0, q_tries));
							if (hd.grp || !hd.resp)
								pop_head();
							else if (q_tries != artq_pkg::TRIES_MAX)
								q_tries++;
							q_timer = '0;
						end
					end
				end
			end
			artq_pkg::OP_FOUND: begin
				if (q_count == 0) begin
					outs.push_back(describe(artq_pkg::EV_DONE, nd, 0, 0, '0));
				end else begin
					q_store[q_head].rep   = it.rep;
					q_store[q_head].slot  = it.slot;
					q_store[q_head].bcast = 1'b0;
					outs.push_back(describe(artq_pkg::EV_DONE, q_store[q_head], 1, 0, '0));
				end
			end
			artq_pkg::OP_REMOVE: begin
				if (q_count == 0) begin
					outs.push_back(describe(artq_pkg::EV_DONE, nd, 0, 0, '0));
				end else begin
					hd = q_store[q_head];
					pop_head();
					outs.push_back(describe(artq_pkg::EV_DONE, hd, 1, 0, '0));
				end
			end
			artq_pkg::OP_RTIMER: begin
				q_timer = '0;
				outs.push_back(describe(artq_pkg::EV_DONE, nd, 0, 0, '0));
			end
			default: outs.push_back(describe(artq_pkg::EV_DONE, nd, 0, 0, '0));
		endcase
		foreach (outs[k]) begin
			outs[k].count = q_count[4:0];
			outs[k].last  = (k == outs.size() - 1);
			due_events.push_back(outs[k]);
		end
	endfunction

	function automatic txq_item_t mk(input logic [2:0] o, input logic tk, input logic bz,
			input logic [15:0] h, input logic bc, input logic [15:0] rp, input logic sl,
			input logic gr, input logic rs, input logic [15:0] at);
		txq_item_t it;
		it = '{o, tk, bz, h, bc, rp, sl, gr, rs, at};
		return it;
	endfunction

	function automatic txq_item_t random_item(input int add_pct);
		txq_item_t it;
		int pick;
		it.tick   = ($urandom_range(99) < 70);
		it.busy   = ($urandom_range(99) < 15);
		it.handle = 16'($urandom);
		it.bcast  = 1'($urandom_range(1));
		it.rep    = 16'($urandom);
		it.slot   = 1'($urandom_range(1));
		it.grp    = ($urandom_range(99) < 25);
		it.resp   = ($urandom_range(99) < 75);
		pick = $urandom_range(9);
		if (pick < 6)
			it.air = 16'($urandom_range(2000));
		else if (pick < 8)
			it.air = 16'($urandom_range(999));
		else if (pick == 8)
			it.air = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
		else
			it.air = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < add_pct) begin
			it.op = artq_pkg::OP_ADD;
		end else begin
			pick = $urandom_range(99);
			if (pick < 60)
				it.op = artq_pkg::OP_POLL;
			else if (pick < 70)
				it.op = artq_pkg::OP_FOUND;
			else if (pick < 85)
				it.op = artq_pkg::OP_REMOVE;
			else if (pick < 93)
				it.op = artq_pkg::OP_RTIMER;
			else begin
				case ($urandom_range(2))
					0: it.op = OP_SPARE_A;
					1: it.op = OP_SPARE_B;
					default: it.op = OP_SPARE_C;
				endcase
			end
		end
		return it;
	endfunction

	task automatic queue_item(input txq_item_t it);
		backlog.push_back(it);
		n_loaded++;
	endtask

	// Hold off until every item is in and every result is out, then settle
	task automatic drain();
		while (n_taken != n_loaded || due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic reg_idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == artq_pkg::REG_MIN_RETRY)
			cfg_min_retry = data[15:0];
		else
			cfg_max_tries = data[7:0];
	endtask

	// Input side: present queued items, record each transfer in the shadow
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				retx_queue_step(on_bus);
				n_taken++;
				ops_seen[on_bus.op]++;
			end
			if (!in_valid || !in_stall) begin
				if (backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					on_bus = backlog.pop_front();
					op             <= on_bus.op;
					tick           <= on_bus.tick;
					channel_busy   <= on_bus.busy;
					packet_handle  <= on_bus.handle;
					broadcast      <= on_bus.bcast;
					repeater_id    <= on_bus.rep;
					timeslot       <= on_bus.slot;
					dest_is_group  <= on_bus.grp;
					wants_response <= on_bus.resp;
					airtime_ms     <= on_bus.air;
					in_valid       <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic cmp_field(input string name, input logic [16:0] got_v,
			input logic [16:0] want_v);
		if (got_v !== want_v)
			report_fault($sformatf("result %0d field %s: got %0h, want %0h",
				n_checked, name, got_v, want_v));
	endtask

	// Output side: random stall, check each result transfer against the oldest one due
	always @(posedge clk) begin
		artq_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_events.size() == 0) begin
					report_fault($sformatf("result with nothing due: event %0d handle %0h",
						event_res, out_handle));
				end else begin
					want = due_events.pop_front();
					cmp_field("event_res", 17'(event_res), 17'(want.ev));
					cmp_field("out_handle", 17'(out_handle), 17'(want.handle));
					cmp_field("out_broadcast", 17'(out_broadcast), 17'(want.bcast));
					cmp_field("out_repeater", 17'(out_repeater), 17'(want.repeater));
					cmp_field("out_timeslot", 17'(out_timeslot), 17'(want.slot));
					cmp_field("wait_seconds", wait_seconds, want.wait_sec);
					cmp_field("try_number", 17'(try_number), 17'(want.tries));
					cmp_field("queue_count", 17'(queue_count), 17'(want.count));
					cmp_field("last", 17'(last), 17'(want.last));
				end
				n_checked++;
				ev_seen[event_res]++;
			end
			out_stall <= ($urandom_range(99) < snk_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int min_tab [6];
		int tries_tab [6];
		int add_tab [6];
		min_tab   = '{0, 65535, 0, 1, 0, 2};
		tries_tab = '{0, 255, 1, 2, 0, 255};
		add_tab   = '{45, 70, 40, 40, 45, 35};
		min_tab[4]   = $urandom_range(3);
		tries_tab[4] = $urandom_range(4);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty queue, spare ops, extremes, wait/send/found/remove
		queue_item(mk(artq_pkg::OP_POLL, 1, 0, 16'h0, 0, 16'h0, 0, 0, 0, 16'h0));
		queue_item(mk(artq_pkg::OP_FOUND, 0, 0, 16'h0, 0, 16'hFFFF, 1, 0, 0, 16'h0));
		queue_item(mk(artq_pkg::OP_REMOVE, 0, 0, 16'h0, 0, 16'h0, 0, 0, 0, 16'h0));
		queue_item(mk(OP_SPARE_A, 1, 1, 16'hFFFF, 1, 16'hFFFF, 1, 1, 1, 16'hFFFF));
		queue_item(mk(OP_SPARE_B, 0, 1, 16'h5A5A, 1, 16'h1234, 0, 1, 0, 16'h00FF));
		queue_item(mk(OP_SPARE_C, 1, 0, 16'hA5A5, 0, 16'h4321, 1, 0, 1, 16'hFF00));
		queue_item(mk(artq_pkg::OP_ADD, 0, 0, 16'hFFFF, 1, 16'hFFFF, 1, 0, 1, 16'd2500));
		queue_item(mk(artq_pkg::OP_ADD, 0, 0, 16'h0000, 0, 16'h0000, 0, 1, 1, 16'd0));
		queue_item(mk(artq_pkg::OP_ADD, 0, 0, 16'h1234, 0, 16'h5678, 0, 0, 0, 16'hFFFF));
		// timer still saturated: busy wait with nothing left, then an immediate send
		queue_item(mk(artq_pkg::OP_POLL, 1, 1, 16'h0, 0, 16'h0, 0, 0, 0, 16'h0));
		queue_item(mk(artq_pkg::OP_POLL, 0, 0, 16'h0, 0, 16'h0, 0, 0, 0, 16'h0));
		queue_item(mk(artq_pkg::OP_POLL, 1, 0, 16'h0, 0, 16'h0, 0, 0, 0, 16'h0));
		queue_item(mk(artq_pkg::OP_FOUND, 0, 0, 16'h0, 1, 16'hA5A5, 0, 0, 0, 16'h0));
		queue_item(mk(artq_pkg::OP_RTIMER, 1, 1, 16'hFFFF, 1, 16'hFFFF, 1, 1, 1, 16'hFFFF));
		queue_item(mk(artq_pkg::OP_POLL, 1, 1, 16'h0, 0, 16'h0, 0, 0, 0, 16'h0));
		queue_item(mk(artq_pkg::OP_REMOVE, 0, 0, 16'h0, 0, 16'h0, 0, 0, 0, 16'h0));
		// group entry counts up to its interval, is sent once and leaves
		repeat (4) queue_item(mk(artq_pkg::OP_POLL, 1, 0, 16'h0, 0, 16'h0, 0, 0, 0, 16'h0));
		queue_item(mk(artq_pkg::OP_POLL, 1, 0, 16'h0, 0, 16'h0, 0, 0, 0, 16'h0));
		drain();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				src_idle_pct  = 52;
				snk_stall_pct = 7;
			end else if (ph == 4) begin
				src_idle_pct  = 0;
				snk_stall_pct = 0;
			end
			reg_write(artq_pkg::REG_MIN_RETRY, 32'(min_tab[ph]));
			reg_write(artq_pkg::REG_MAX_TRIES, 32'(tries_tab[ph]));
			repeat (PHASE_ITEMS) queue_item(random_item(add_tab[ph]));
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d transfers: add %0d, poll %0d, found %0d, remove %0d,",
			n_taken, ops_seen[artq_pkg::OP_ADD], ops_seen[artq_pkg::OP_POLL],
			ops_seen[artq_pkg::OP_FOUND], ops_seen[artq_pkg::OP_REMOVE]);
		$display("  timer %0d, spare %0d; checked %0d results over seven register settings:",
			ops_seen[artq_pkg::OP_RTIMER],
			ops_seen[OP_SPARE_A] + ops_seen[OP_SPARE_B] + ops_seen[OP_SPARE_C],
			n_checked);
		$display("  %0d sends, %0d give-ups, %0d waits, %0d full rejects",
			ev_seen[artq_pkg::EV_SEND], ev_seen[artq_pkg::EV_GAVE_UP],
			ev_seen[artq_pkg::EV_WAIT], ev_seen[artq_pkg::EV_FULL]);
		if (fault_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/artq_pkg.sv
rtl/core/artq_front.sv
rtl/core/artq_back.sv
rtl/core/ack_retry_tx_queue_core.sv
test/tb_ack_retry_tx_queue_core.sv
